### hdl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Types, codes and fixed-point constants shared by the compositor modules.
// ----------------------------------------------------------------------------
package pdc_pkg;

   localparam int CHAN_W      = 8;
   localparam int NUM_COLORS  = 3;
   localparam int NUM_STAGES  = 5;

   localparam int WEIGHT_W    = 2 * CHAN_W;
   localparam int PROD_W      = WEIGHT_W + CHAN_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int ALPHA_SUM_W = WEIGHT_W + 1;
   localparam int QUOT_W      = CHAN_W + 1;

   localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

   // Exact floor division by 65025 for any 25-bit sum, and by 255 for any
   // 17-bit sum, as a multiplication by a rounded-up reciprocal.
   localparam int                     RECIP_COLOR_W = 26;
   localparam logic [RECIP_COLOR_W-1:0] RECIP_COLOR = 26'd33818121;
   localparam int                     SHIFT_COLOR   = 41;
   localparam int                     RECIP_ALPHA_W = 18;
   localparam logic [RECIP_ALPHA_W-1:0] RECIP_ALPHA = 18'd131587;
   localparam int                     SHIFT_ALPHA   = 25;

   localparam int MODE_W = 4;
   localparam logic [MODE_W-1:0] MODE_PASS      = 4'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_COPY      = 4'd2;
   localparam logic [MODE_W-1:0] MODE_DEST      = 4'd3;
   localparam logic [MODE_W-1:0] MODE_SRC_OVER  = 4'd4;
   localparam logic [MODE_W-1:0] MODE_DEST_OVER = 4'd5;
   localparam logic [MODE_W-1:0] MODE_SRC_IN    = 4'd6;
   localparam logic [MODE_W-1:0] MODE_DEST_IN   = 4'd7;
   localparam logic [MODE_W-1:0] MODE_SRC_OUT   = 4'd8;
   localparam logic [MODE_W-1:0] MODE_DEST_OUT  = 4'd9;
   localparam logic [MODE_W-1:0] MODE_SRC_ATOP  = 4'd10;
   localparam logic [MODE_W-1:0] MODE_DEST_ATOP = 4'd11;
   localparam logic [MODE_W-1:0] MODE_XOR       = 4'd12;
   localparam logic [MODE_W-1:0] MODE_LIGHTER   = 4'd13;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_MODE_IDX = 1'b0;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic load_first;
      logic load_second;
   } load_pair_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] src_weight;
      logic [WEIGHT_W-1:0] dst_weight;
      pixel_type           src;
      pixel_type           dst;
      logic                pass;
   } weight_stage_type;

   typedef struct packed {
      logic [NUM_COLORS-1:0][SUM_W-1:0] color_sum;
      logic [ALPHA_SUM_W-1:0]           alpha_sum;
      pixel_type                        src;
      logic                             pass;
   } sum_stage_type;

endpackage

### hdl/pdc_csr.sv
// ----------------------------------------------------------------------------
// pdc_csr
// Register port holding the composite mode.
// ----------------------------------------------------------------------------
module pdc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pdc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pdc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pdc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output logic [pdc_pkg::MODE_W-1:0]         mode
);
   import pdc_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic [MODE_W-1:0] mode_in;
   logic              reg_index;
   logic              mode_write;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1];
   assign mode_write = csr_psel && csr_penable && csr_pwrite && (reg_index == CSR_MODE_IDX);
   assign mode_in    = mode_write ? csr_pwdata[MODE_W-1:0] : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SRC_OVER;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (reg_index == CSR_MODE_IDX) ?
                       {{(CSR_DATA_W-MODE_W){1'b0}}, mode_ff} : '0;
   assign mode       = mode_ff;

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      mode_write |=> mode_ff == $past(csr_pwdata[MODE_W-1:0]))
      else $error("Mode register did not take the written value.");

endmodule

### hdl/pdc_weight.sv
// ----------------------------------------------------------------------------
// pdc_weight
// First stage: picks the Porter-Duff factors and scales them by alpha.
// ----------------------------------------------------------------------------
module pdc_weight (
   input  logic                        clock,
   input  logic                        load,
   input  logic [pdc_pkg::MODE_W-1:0]  mode,
   input  pdc_pkg::pixel_type          src,
   input  pdc_pkg::pixel_type          dst,
   output pdc_pkg::weight_stage_type   stage
);
   import pdc_pkg::*;

   logic [CHAN_W-1:0] fa;
   logic [CHAN_W-1:0] fb;
   logic [CHAN_W-1:0] inv_sa;
   logic [CHAN_W-1:0] inv_da;
   weight_stage_type  stage_ff;
   weight_stage_type  stage_in;

   assign inv_sa = FULL_SCALE - src.alpha;
   assign inv_da = FULL_SCALE - dst.alpha;

   always_comb begin
      case (mode)
         MODE_COPY: begin
            fa = FULL_SCALE; fb = '0;
         end
         MODE_DEST: begin
            fa = '0; fb = FULL_SCALE;
         end
         MODE_SRC_OVER: begin
            fa = FULL_SCALE; fb = inv_sa;
         end
         MODE_DEST_OVER: begin
            fa = inv_da; fb = FULL_SCALE;
         end
         MODE_SRC_IN: begin
            fa = dst.alpha; fb = '0;
         end
         MODE_DEST_IN: begin
            fa = '0; fb = src.alpha;
         end
         MODE_SRC_OUT: begin
            fa = inv_da; fb = '0;
         end
         MODE_DEST_OUT: begin
            fa = '0; fb = inv_sa;
         end
         MODE_SRC_ATOP: begin
            fa = dst.alpha; fb = inv_sa;
         end
         MODE_DEST_ATOP: begin
            fa = inv_da; fb = src.alpha;
         end
         MODE_XOR: begin
            fa = inv_da; fb = inv_sa;
         end
         MODE_LIGHTER: begin
            fa = FULL_SCALE; fb = FULL_SCALE;
         end
         default: begin
            fa = '0; fb = '0;
         end
      endcase
   end

   always_comb begin
      stage_in.src_weight = WEIGHT_W'(fa) * WEIGHT_W'(src.alpha);
      stage_in.dst_weight = WEIGHT_W'(fb) * WEIGHT_W'(dst.alpha);
      stage_in.src        = src;
      stage_in.dst        = dst;
      stage_in.pass       = (mode == MODE_PASS);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

### hdl/pdc_mix.sv
// ----------------------------------------------------------------------------
// pdc_mix
// Second and third stages: per-channel products, then the weighted sums.
// ----------------------------------------------------------------------------
module pdc_mix (
   input  logic                       clock,
   input  pdc_pkg::load_pair_type     load,
   input  pdc_pkg::weight_stage_type  weight,
   output pdc_pkg::sum_stage_type     stage
);
   import pdc_pkg::*;

   logic [NUM_COLORS-1:0][CHAN_W-1:0] src_color;
   logic [NUM_COLORS-1:0][CHAN_W-1:0] dst_color;
   logic [NUM_COLORS-1:0][PROD_W-1:0] src_prod_ff;
   logic [NUM_COLORS-1:0][PROD_W-1:0] src_prod_in;
   logic [NUM_COLORS-1:0][PROD_W-1:0] dst_prod_ff;
   logic [NUM_COLORS-1:0][PROD_W-1:0] dst_prod_in;
   logic [ALPHA_SUM_W-1:0]            alpha_sum_ff;
   logic [ALPHA_SUM_W-1:0]            alpha_sum_in;
   pixel_type                         src_ff;
   logic                              pass_ff;
   sum_stage_type                     stage_ff;
   sum_stage_type                     stage_in;

   assign src_color = {weight.src.red, weight.src.green, weight.src.blue};
   assign dst_color = {weight.dst.red, weight.dst.green, weight.dst.blue};

   always_comb begin
      for (int i = 0; i < NUM_COLORS; i++) begin
         src_prod_in[i] = PROD_W'(weight.src_weight) * PROD_W'(src_color[i]);
         dst_prod_in[i] = PROD_W'(weight.dst_weight) * PROD_W'(dst_color[i]);
      end
      alpha_sum_in = {1'b0, weight.src_weight} + {1'b0, weight.dst_weight};
   end

   always_ff @(posedge clock) begin
      if (load.load_first) begin
         src_prod_ff  <= src_prod_in;
         dst_prod_ff  <= dst_prod_in;
         alpha_sum_ff <= alpha_sum_in;
         src_ff       <= weight.src;
         pass_ff      <= weight.pass;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_COLORS; i++) begin
         stage_in.color_sum[i] = {1'b0, src_prod_ff[i]} + {1'b0, dst_prod_ff[i]};
      end
      stage_in.alpha_sum = alpha_sum_ff;
      stage_in.src       = src_ff;
      stage_in.pass      = pass_ff;
   end

   always_ff @(posedge clock) begin
      if (load.load_second) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

### hdl/pdc_norm.sv
// ----------------------------------------------------------------------------
// pdc_norm
// Fourth and fifth stages: reciprocal scaling, saturation and output select.
// ----------------------------------------------------------------------------
module pdc_norm (
   input  logic                    clock,
   input  pdc_pkg::load_pair_type  load,
   input  pdc_pkg::sum_stage_type  sums,
   output pdc_pkg::pixel_type      pixel
);
   import pdc_pkg::*;

   localparam int COLOR_PROD_W = SUM_W + RECIP_COLOR_W;
   localparam int ALPHA_PROD_W = ALPHA_SUM_W + RECIP_ALPHA_W;

   logic [NUM_COLORS-1:0][COLOR_PROD_W-1:0] color_prod;
   logic [ALPHA_PROD_W-1:0]                 alpha_prod;
   logic [NUM_COLORS-1:0][QUOT_W-1:0]       color_quot_ff;
   logic [NUM_COLORS-1:0][QUOT_W-1:0]       color_quot_in;
   logic [QUOT_W-1:0]                       alpha_quot_ff;
   logic [QUOT_W-1:0]                       alpha_quot_in;
   pixel_type                               src_ff;
   logic                                    pass_ff;
   logic [NUM_COLORS-1:0][CHAN_W-1:0]       color_sat;
   logic [CHAN_W-1:0]                       alpha_sat;
   pixel_type                               pixel_ff;
   pixel_type                               pixel_in;

   function automatic logic [CHAN_W-1:0] saturate(input logic [QUOT_W-1:0] value);
      logic [CHAN_W-1:0] result;
      result = (value > QUOT_W'(FULL_SCALE)) ? FULL_SCALE : value[CHAN_W-1:0];
      return result;
   endfunction

   always_comb begin
      for (int i = 0; i < NUM_COLORS; i++) begin
         color_prod[i]    = COLOR_PROD_W'(sums.color_sum[i]) * COLOR_PROD_W'(RECIP_COLOR);
         color_quot_in[i] = color_prod[i][SHIFT_COLOR +: QUOT_W];
      end
      alpha_prod    = ALPHA_PROD_W'(sums.alpha_sum) * ALPHA_PROD_W'(RECIP_ALPHA);
      alpha_quot_in = alpha_prod[SHIFT_ALPHA +: QUOT_W];
   end

   always_ff @(posedge clock) begin
      if (load.load_first) begin
         color_quot_ff <= color_quot_in;
         alpha_quot_ff <= alpha_quot_in;
         src_ff        <= sums.src;
         pass_ff       <= sums.pass;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_COLORS; i++) begin
         color_sat[i] = saturate(color_quot_ff[i]);
      end
      alpha_sat = saturate(alpha_quot_ff);
      if (pass_ff) begin
         pixel_in = src_ff;
      end else begin
         pixel_in.red   = color_sat[2];
         pixel_in.green = color_sat[1];
         pixel_in.blue  = color_sat[0];
         pixel_in.alpha = alpha_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load_second) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule

### hdl/porter_duff_pixel_compositor.sv
// ----------------------------------------------------------------------------
// porter_duff_pixel_compositor
// Composites a source RGBA pixel over a destination pixel by a Porter-Duff rule.
// ----------------------------------------------------------------------------
// The block takes one source and destination pixel pair per clock when not
// stalled and returns the composited pixel through a five-stage pipeline (factor
// select, channel products, sums, reciprocal scaling, saturation). Each stage
// holds while the stage after it is full and stalled, so empty stages fill in
// and a request is taken whenever any stage is free. The user must write the
// mode register only while no request is in flight; the block does not enforce it.
module porter_duff_pixel_compositor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [pdc_pkg::CHAN_W-1:0]         req_src_red,
   input  logic [pdc_pkg::CHAN_W-1:0]         req_src_green,
   input  logic [pdc_pkg::CHAN_W-1:0]         req_src_blue,
   input  logic [pdc_pkg::CHAN_W-1:0]         req_src_alpha,
   input  logic [pdc_pkg::CHAN_W-1:0]         req_dst_red,
   input  logic [pdc_pkg::CHAN_W-1:0]         req_dst_green,
   input  logic [pdc_pkg::CHAN_W-1:0]         req_dst_blue,
   input  logic [pdc_pkg::CHAN_W-1:0]         req_dst_alpha,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pdc_pkg::CHAN_W-1:0]         rsp_out_red,
   output logic [pdc_pkg::CHAN_W-1:0]         rsp_out_green,
   output logic [pdc_pkg::CHAN_W-1:0]         rsp_out_blue,
   output logic [pdc_pkg::CHAN_W-1:0]         rsp_out_alpha,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pdc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pdc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pdc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import pdc_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_ready;
   logic [MODE_W-1:0]     mode;
   pixel_type             src;
   pixel_type             dst;
   pixel_type             result;
   weight_stage_type      weight;
   sum_stage_type         sums;
   load_pair_type         mix_load;
   load_pair_type         norm_load;

   always_comb begin
      stage_ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      valid_in[0] = stage_ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = stage_ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign src = '{red: req_src_red, green: req_src_green, blue: req_src_blue,
                  alpha: req_src_alpha};
   assign dst = '{red: req_dst_red, green: req_dst_green, blue: req_dst_blue,
                  alpha: req_dst_alpha};

   assign mix_load  = '{load_first: stage_ready[1], load_second: stage_ready[2]};
   assign norm_load = '{load_first: stage_ready[3], load_second: stage_ready[4]};

   pdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mode        (mode)
   );

   pdc_weight u_weight (
      .clock (clock),
      .load  (stage_ready[0]),
      .mode  (mode),
      .src   (src),
      .dst   (dst),
      .stage (weight)
   );

   pdc_mix u_mix (
      .clock  (clock),
      .load   (mix_load),
      .weight (weight),
      .stage  (sums)
   );

   pdc_norm u_norm (
      .clock (clock),
      .load  (norm_load),
      .sums  (sums),
      .pixel (result)
   );

   assign req_stall     = !stage_ready[0];
   assign rsp_valid     = valid_ff[NUM_STAGES-1];
   assign rsp_out_red   = result.red;
   assign rsp_out_green = result.green;
   assign rsp_out_blue  = result.blue;
   assign rsp_out_alpha = result.alpha;

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("Request stalled while a pipeline stage was empty.");

   a_flow_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("Request stalled although the output side was free.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("Pipeline holds a request right after reset.");

endmodule
